### design/midi_sx_pkg.sv
package midi_sx_pkg;

    localparam int unsigned ID_W   = 7;
    localparam int unsigned DATA_W = 7;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_THIRD  = 2'd2;

    // system bytes
    localparam logic [BYTE_W-1:0] MSG_SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] MSG_MTC_QUARTER = 8'hF1;
    localparam logic [BYTE_W-1:0] MSG_SONG_POS    = 8'hF2;
    localparam logic [BYTE_W-1:0] MSG_SONG_SELECT = 8'hF3;
    localparam logic [BYTE_W-1:0] MSG_SYSEX_END   = 8'hF7;
    localparam logic [BYTE_W-1:0] MSG_CLOCK       = 8'hF8;
    localparam logic [BYTE_W-1:0] MSG_START       = 8'hFA;
    localparam logic [BYTE_W-1:0] MSG_CONTINUE    = 8'hFB;
    localparam logic [BYTE_W-1:0] MSG_STOP        = 8'hFC;

    // channel status high nibbles
    localparam logic [3:0] CH_NOTE_OFF    = 4'h8;
    localparam logic [3:0] CH_NOTE_ON     = 4'h9;
    localparam logic [3:0] CH_POLY_PRESS  = 4'hA;
    localparam logic [3:0] CH_CONTROLLER  = 4'hB;
    localparam logic [3:0] CH_PROG_CHANGE = 4'hC;
    localparam logic [3:0] CH_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] CH_PITCH_BEND  = 4'hE;
    localparam logic [3:0] CH_SYSTEM      = 4'hF;

    typedef enum logic [2:0] {
        KIND_REALTIME     = 3'd0,
        KIND_CHANNEL      = 3'd1,
        KIND_SYSEX_PARAM  = 3'd2,
        KIND_SYSEX_ACCEPT = 3'd3,
        KIND_SYSEX_REJECT = 3'd4
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] status_byte;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
        logic [DATA_W-1:0] third_data;
        logic [DATA_W-1:0] fourth_data;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0] id_first;
        logic [ID_W-1:0] id_second;
        logic [ID_W-1:0] id_third;
    } sysex_id_t;

endpackage

### design/midi_stream_parser_sysex_top.sv
// midi byte stream parser with running status and a sysex parameter path
//
// input channel s_*: one received midi byte per request (s_rx_byte)
// result channel m_*: zero or one result per byte; m_kind tells realtime,
// channel message, sysex parameter quartet, sysex accepted or rejected
// configuration: cfg_we writes cfg_data into register cfg_index
// (0..2 = the three sysex id bytes); other indexes are ignored
//
// a byte accepted into the input register is parsed and its result is
// registered in the result register, which drives m_valid
// throughput: one byte per cycle while no result is stalled, set by the
// single parse step between the input register and the result register
// bytes that give no result just update the parser state
// reset: parser state, id registers and the valid flags of both pipeline
// registers clear; s_ready stays low until the first cycle after reset
// stall: while m_ready is low a result is held; an empty input register
// takes one more byte, then s_ready drops until the result is taken
module midi_stream_parser_sysex_top
    import midi_sx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_rx_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_kind,
    output logic [BYTE_W-1:0]      m_status_byte,
    output logic [DATA_W-1:0]      m_first_data,
    output logic [DATA_W-1:0]      m_second_data,
    output logic [DATA_W-1:0]      m_third_data,
    output logic [DATA_W-1:0]      m_fourth_data,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]        cfg_data
);

    logic              ready_en_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    sysex_id_t         sysex_id_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance;

    assign advance = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready = ready_en_reg && (!in_valid_reg || advance);

    midi_sx_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (advance),
        .rx_byte  (in_byte_reg),
        .sysex_id (sysex_id_reg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_en_reg <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            ready_en_reg <= 1'b1;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg.valid <= result.valid;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_reg.kind        <= result.kind;
            out_reg.status_byte <= result.status_byte;
            out_reg.first_data  <= result.first_data;
            out_reg.second_data <= result.second_data;
            out_reg.third_data  <= result.third_data;
            out_reg.fourth_data <= result.fourth_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sysex_id_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ID_FIRST:  sysex_id_reg.id_first  <= cfg_data;
                CFG_ID_SECOND: sysex_id_reg.id_second <= cfg_data;
                CFG_ID_THIRD:  sysex_id_reg.id_third  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_valid       = out_reg.valid;
    assign m_kind        = out_reg.kind;
    assign m_status_byte = out_reg.status_byte;
    assign m_first_data  = out_reg.first_data;
    assign m_second_data = out_reg.second_data;
    assign m_third_data  = out_reg.third_data;
    assign m_fourth_data = out_reg.fourth_data;

endmodule

### design/midi_sx_core.sv
module midi_sx_core
    import midi_sx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [BYTE_W-1:0] rx_byte,
    input  sysex_id_t         sysex_id,
    output result_t           result
);

    typedef enum logic [8:0] {
        PH_NONE   = 9'b000000001,
        PH_IGNORE = 9'b000000010,
        PH_ID0    = 9'b000000100,
        PH_ID1    = 9'b000001000,
        PH_ID2    = 9'b000010000,
        PH_PARH   = 9'b000100000,
        PH_PARL   = 9'b001000000,
        PH_VALH   = 9'b010000000,
        PH_VALL   = 9'b100000000
    } phase_t;

    logic [BYTE_W-1:0] running_status_reg, running_status_next;
    logic [1:0]        params_needed_reg, params_needed_next;
    logic [1:0]        params_seen_reg, params_seen_next;
    logic [DATA_W-1:0] param_store_reg [2];
    logic [DATA_W-1:0] param_store_next [2];
    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] param_high_reg, param_high_next;
    logic [DATA_W-1:0] param_low_reg, param_low_next;
    logic [DATA_W-1:0] value_high_reg, value_high_next;

    logic [1:0]        seen_inc;
    logic [3:0]        rs_nibble;
    logic [DATA_W-1:0] data7;

    assign seen_inc  = params_seen_reg + 2'd1;
    assign rs_nibble = running_status_reg[7:4];
    assign data7     = rx_byte[DATA_W-1:0];

    always_comb begin
        running_status_next = running_status_reg;
        params_needed_next  = params_needed_reg;
        params_seen_next    = params_seen_reg;
        param_store_next    = param_store_reg;
        phase_next          = phase_reg;
        param_high_next     = param_high_reg;
        param_low_next      = param_low_reg;
        value_high_next     = value_high_reg;
        result              = '0;

        if (rx_byte[7:4] == CH_SYSTEM) begin
            unique case (rx_byte) inside
                MSG_CLOCK, MSG_START, MSG_CONTINUE, MSG_STOP: begin
                    result.valid       = 1'b1;
                    result.kind        = KIND_REALTIME;
                    result.status_byte = rx_byte;
                end
                MSG_MTC_QUARTER, MSG_SONG_POS, MSG_SONG_SELECT: begin
                    params_seen_next    = 2'd0;
                    running_status_next = rx_byte;
                    params_needed_next  = (rx_byte == MSG_SONG_POS) ? 2'd2 : 2'd1;
                end
                MSG_SYSEX_START: begin
                    phase_next = PH_ID0;
                end
                MSG_SYSEX_END: begin
                    phase_next = PH_NONE;
                    if (phase_reg != PH_NONE && phase_reg != PH_IGNORE) begin
                        result.valid = 1'b1;
                        result.kind  = (phase_reg == PH_PARH) ? KIND_SYSEX_ACCEPT
                                                              : KIND_SYSEX_REJECT;
                    end
                end
                default: begin
                end
            endcase
        end else if (rx_byte[7]) begin
            // channel status aborts any sysex block
            phase_next          = PH_NONE;
            params_seen_next    = 2'd0;
            running_status_next = rx_byte;
            params_needed_next  = (rx_byte[7:4] == CH_PROG_CHANGE ||
                                   rx_byte[7:4] == CH_CHAN_PRESS) ? 2'd1 : 2'd2;
        end else begin
            unique case (phase_reg)
                PH_ID0: phase_next = (data7 == sysex_id.id_first)  ? PH_ID1  : PH_IGNORE;
                PH_ID1: phase_next = (data7 == sysex_id.id_second) ? PH_ID2  : PH_IGNORE;
                PH_ID2: phase_next = (data7 == sysex_id.id_third)  ? PH_PARH : PH_IGNORE;
                PH_PARH: begin
                    param_high_next = data7;
                    phase_next      = PH_PARL;
                end
                PH_PARL: begin
                    param_low_next = data7;
                    phase_next     = PH_VALH;
                end
                PH_VALH: begin
                    value_high_next = data7;
                    phase_next      = PH_VALL;
                end
                PH_VALL: begin
                    phase_next         = PH_PARH;
                    result.valid       = 1'b1;
                    result.kind        = KIND_SYSEX_PARAM;
                    result.first_data  = param_high_reg;
                    result.second_data = param_low_reg;
                    result.third_data  = value_high_reg;
                    result.fourth_data = data7;
                end
                PH_NONE: begin
                    if (running_status_reg != '0) begin
                        param_store_next[params_seen_reg[0]] = data7;
                        params_seen_next = seen_inc;
                        if (seen_inc >= params_needed_reg) begin
                            params_seen_next = 2'd0;
                            if (rs_nibble == CH_NOTE_OFF || rs_nibble == CH_NOTE_ON ||
                                rs_nibble == CH_PITCH_BEND || rs_nibble == CH_CONTROLLER ||
                                rs_nibble == CH_CHAN_PRESS) begin
                                result.valid       = 1'b1;
                                result.kind        = KIND_CHANNEL;
                                result.status_byte = running_status_reg;
                                result.first_data  = param_store_next[0];
                                result.second_data = param_store_next[1];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_status_reg <= '0;
            params_needed_reg  <= '0;
            params_seen_reg    <= '0;
            param_store_reg[0] <= '0;
            param_store_reg[1] <= '0;
            phase_reg          <= PH_NONE;
            param_high_reg     <= '0;
            param_low_reg      <= '0;
            value_high_reg     <= '0;
        end else if (fire) begin
            running_status_reg <= running_status_next;
            params_needed_reg  <= params_needed_next;
            params_seen_reg    <= params_seen_next;
            param_store_reg    <= param_store_next;
            phase_reg          <= phase_next;
            param_high_reg     <= param_high_next;
            param_low_reg      <= param_low_next;
            value_high_reg     <= value_high_next;
        end
    end

endmodule

### design/midi_sx_checker.sv
module midi_sx_checker
    import midi_sx_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_kind,
    input logic [BYTE_W-1:0] m_status_byte,
    input logic [DATA_W-1:0] m_first_data,
    input logic [DATA_W-1:0] m_second_data,
    input logic [DATA_W-1:0] m_third_data,
    input logic [DATA_W-1:0] m_fourth_data
);

    // a stalled result holds its valid, kind, status and first and fourth data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_status_byte)
            && $stable(m_first_data) && $stable(m_fourth_data))
        else $error("result changed while stalled");

    // realtime results carry a realtime byte and no data
    a_realtime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_REALTIME |->
            m_status_byte[7:3] == 5'b11111 && m_first_data == '0 &&
            m_second_data == '0 && m_third_data == '0 && m_fourth_data == '0)
        else $error("bad realtime result");

    // channel results carry a status byte and only two data bytes
    a_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_CHANNEL |->
            m_status_byte[7] && m_status_byte[7:4] != CH_SYSTEM &&
            m_third_data == '0 && m_fourth_data == '0)
        else $error("bad channel result");

    // sysex end results are empty and no unknown kind leaves the block
    a_sysex_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_REALTIME && m_kind != KIND_CHANNEL |->
            m_status_byte == '0 &&
            (m_kind == KIND_SYSEX_PARAM ||
             ((m_kind == KIND_SYSEX_ACCEPT || m_kind == KIND_SYSEX_REJECT) &&
              m_first_data == '0 && m_second_data == '0 &&
              m_third_data == '0 && m_fourth_data == '0)))
        else $error("bad sysex result");

endmodule

bind midi_stream_parser_sysex_top midi_sx_checker u_midi_sx_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_status_byte (m_status_byte),
    .m_first_data  (m_first_data),
    .m_second_data (m_second_data),
    .m_third_data  (m_third_data),
    .m_fourth_data (m_fourth_data)
);
